>>> hdl/topm_pkg.sv
package topm_pkg;

   // item operation codes
   typedef enum logic [0:0] {
      OP_LOAD   = 1'b0,
      OP_UPDATE = 1'b1
   } op_type;

   // number of lanes an item carries
   localparam int unsigned MAX_LANES = 4;

   // per-cell enables, from the accumulate stage
   typedef struct packed {
      logic load_en;
      logic update_en;
   } cell_ctrl_type;

   // Q32.32 to Q16.16: round to nearest, ties up, saturate to 32 bits
   function automatic logic signed [31:0] to_q16(input logic signed [63:0] acc);
      logic signed [64:0] biased;
      logic signed [48:0] q;
      begin
         biased = {acc[63], acc} + 65'sd32768;
         q = biased[64:16];
         if (q > 49'sd2147483647) begin
            to_q16 = 32'sh7fffffff;
         end else if (q < -49'sd2147483648) begin
            to_q16 = 32'sh80000000;
         end else begin
            to_q16 = q[31:0];
         end
      end
   endfunction

endpackage

>>> hdl/topm_mac_cell.sv
module topm_mac_cell
   import topm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic signed [31:0]   a_elem,
   input  logic signed [31:0]   b_elem,
   input  logic signed [31:0]   load_value,
   input  cell_ctrl_type        ctrl,
   output logic signed [63:0]   acc
);

   logic signed [63:0] prod_ff;
   logic signed [63:0] prod_in;
   logic signed [63:0] acc_ff;
   logic signed [63:0] acc_in;
   logic signed [64:0] sum;

   // product of the operand slices, registered before the add
   assign prod_in = a_elem * b_elem;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // saturating accumulate or load of an old C value
   always_comb begin
      sum = {acc_ff[63], acc_ff} + {prod_ff[63], prod_ff};
      acc_in = acc_ff;
      if (ctrl.load_en) begin
         acc_in = {{16{load_value[31]}}, load_value, 16'h0000};
      end else if (ctrl.update_en) begin
         if (sum[64] != sum[63]) begin
            acc_in = sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
         end else begin
            acc_in = sum[63:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

>>> hdl/tile_outer_product_mac.sv
// pipeline: an item is registered, multiplied in the next cycle and added into the
// accumulators in the one after; once the final update beat is added, the columns of
// a tile leave via the result register, one column per cycle while rsp_stall is low
// throughput: one load or update beat per cycle; a final update holds req_stall
// until the last column sits in the result register
// reset: clears the pipeline and result valid bits and all accumulators to zero
module tile_outer_product_mac
   import topm_pkg::*;
#(
   parameter int unsigned TILE = 4
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_operation,
   input  logic [1:0]           req_column_index,
   input  logic signed [31:0]   req_a_elem_0,
   input  logic signed [31:0]   req_a_elem_1,
   input  logic signed [31:0]   req_a_elem_2,
   input  logic signed [31:0]   req_a_elem_3,
   input  logic signed [31:0]   req_b_elem_0,
   input  logic signed [31:0]   req_b_elem_1,
   input  logic signed [31:0]   req_b_elem_2,
   input  logic signed [31:0]   req_b_elem_3,
   input  logic                 req_final_update,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_out_column,
   output logic signed [31:0]   rsp_out_row_0,
   output logic signed [31:0]   rsp_out_row_1,
   output logic signed [31:0]   rsp_out_row_2,
   output logic signed [31:0]   rsp_out_row_3,
   output logic                 rsp_tile_done
);

   localparam int unsigned LANES = (TILE < MAX_LANES) ? TILE : MAX_LANES;
   localparam logic [1:0] LAST_COL = 2'(LANES - 1);

   logic                req_beat;
   logic                rsp_beat;

   // input register stage
   logic                s1_valid_ff;
   op_type              s1_op_ff;
   logic [1:0]          s1_col_ff;
   logic                s1_final_ff;
   logic signed [31:0]  s1_a_ff [MAX_LANES];
   logic signed [31:0]  s1_b_ff [MAX_LANES];

   // accumulate stage
   logic                s2_valid_ff;
   op_type              s2_op_ff;
   logic [1:0]          s2_col_ff;
   logic                s2_final_ff;
   logic signed [31:0]  s2_a_ff [MAX_LANES];

   // emission control
   logic                busy_ff;
   logic                busy_in;
   logic                emit_active_ff;
   logic                emit_active_in;
   logic [1:0]          emit_col_ff;
   logic [1:0]          emit_col_in;
   logic                emit_start;
   logic                out_load;
   logic                out_last;

   // result register
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [1:0]          rsp_col_ff;
   logic signed [31:0]  rsp_row_ff [MAX_LANES];
   logic                rsp_done_ff;

   logic signed [63:0]  acc_w [MAX_LANES][MAX_LANES];

   assign req_stall = busy_ff;
   assign req_beat  = req_valid && !req_stall;
   assign rsp_beat  = rsp_valid_ff && !rsp_stall;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_beat;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         s1_op_ff    <= op_type'(req_operation);
         s1_col_ff   <= req_column_index;
         s1_final_ff <= req_final_update;
         s1_a_ff[0]  <= req_a_elem_0;
         s1_a_ff[1]  <= req_a_elem_1;
         s1_a_ff[2]  <= req_a_elem_2;
         s1_a_ff[3]  <= req_a_elem_3;
         s1_b_ff[0]  <= req_b_elem_0;
         s1_b_ff[1]  <= req_b_elem_1;
         s1_b_ff[2]  <= req_b_elem_2;
         s1_b_ff[3]  <= req_b_elem_3;
      end
   end

   // accumulate stage control, lines up with the product registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_op_ff    <= s1_op_ff;
      s2_col_ff   <= s1_col_ff;
      s2_final_ff <= s1_final_ff;
      s2_a_ff     <= s1_a_ff;
   end

   // accumulator cells, only the lanes in use
   for (genvar i = 0; i < MAX_LANES; i++) begin : g_row
      for (genvar j = 0; j < MAX_LANES; j++) begin : g_col
         if (i < LANES && j < LANES) begin : g_cell
            cell_ctrl_type ctrl;
            assign ctrl.load_en   = s2_valid_ff && (s2_op_ff == OP_LOAD)
                                    && (s2_col_ff == 2'(j));
            assign ctrl.update_en = s2_valid_ff && (s2_op_ff == OP_UPDATE);
            topm_mac_cell u_cell (
               .clock      (clock),
               .reset      (reset),
               .a_elem     (s1_a_ff[i]),
               .b_elem     (s1_b_ff[j]),
               .load_value (s2_a_ff[i]),
               .ctrl       (ctrl),
               .acc        (acc_w[i][j])
            );
         end else begin : g_none
            assign acc_w[i][j] = '0;
         end
      end
   end

   // emission sequencing over the tile columns
   assign emit_start = s2_valid_ff && (s2_op_ff == OP_UPDATE) && s2_final_ff;
   assign out_load   = emit_active_ff && (!rsp_valid_ff || !rsp_stall);
   assign out_last   = (emit_col_ff == LAST_COL);

   always_comb begin
      busy_in        = busy_ff;
      emit_active_in = emit_active_ff;
      emit_col_in    = emit_col_ff;
      if (req_beat && (op_type'(req_operation) == OP_UPDATE) && req_final_update) begin
         busy_in = 1'b1;
      end
      if (emit_start) begin
         emit_active_in = 1'b1;
         emit_col_in    = 2'd0;
      end else if (out_load) begin
         if (out_last) begin
            emit_active_in = 1'b0;
            busy_in        = 1'b0;
         end else begin
            emit_col_in = emit_col_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         emit_active_ff <= 1'b0;
         emit_col_ff    <= 2'd0;
      end else begin
         busy_ff        <= busy_in;
         emit_active_ff <= emit_active_in;
         emit_col_ff    <= emit_col_in;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_beat) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_col_ff  <= emit_col_ff;
         rsp_done_ff <= out_last;
         for (int i = 0; i < MAX_LANES; i++) begin
            rsp_row_ff[i] <= to_q16(acc_w[i][emit_col_ff]);
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_column = rsp_col_ff;
   assign rsp_out_row_0  = rsp_row_ff[0];
   assign rsp_out_row_1  = rsp_row_ff[1];
   assign rsp_out_row_2  = rsp_row_ff[2];
   assign rsp_out_row_3  = rsp_row_ff[3];
   assign rsp_tile_done  = rsp_done_ff;

`ifndef SYNTHESIS
   // the pipeline is empty while the tile is being read out
   a_emit_quiet: assert property (@(posedge clock) disable iff (reset)
      emit_active_ff |-> !s1_valid_ff && !s2_valid_ff)
      else $error("item in flight during tile readout");

   // a final update closes the input until readout is done
   a_final_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_beat && req_operation && req_final_update) |=> req_stall)
      else $error("input open after final update beat");

   // only the last column carries the done flag
   a_done_col: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_tile_done) |-> (rsp_out_column == LAST_COL))
      else $error("tile done on a column other than the last");

   // columns of one tile follow without a gap
   a_next_col: assert property (@(posedge clock) disable iff (reset)
      (rsp_beat && !rsp_tile_done) |=> rsp_valid)
      else $error("gap between columns of a tile");
`endif

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb
   import topm_pkg::*;
;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_BEATS = 220;

   // one input beat
   typedef struct {
      op_type             op;
      logic [1:0]         col;
      logic signed [31:0] a [4];
      logic signed [31:0] b [4];
      logic               fin;
   } mac_beat_type;

   // one emitted tile column
   typedef struct {
      logic [1:0]         col;
      logic signed [31:0] rows [4];
      logic               done;
   } tile_column_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_operation = 1'b0;
   logic [1:0]         req_column_index = '0;
   logic signed [31:0] req_a_elem_0 = '0;
   logic signed [31:0] req_a_elem_1 = '0;
   logic signed [31:0] req_a_elem_2 = '0;
   logic signed [31:0] req_a_elem_3 = '0;
   logic signed [31:0] req_b_elem_0 = '0;
   logic signed [31:0] req_b_elem_1 = '0;
   logic signed [31:0] req_b_elem_2 = '0;
   logic signed [31:0] req_b_elem_3 = '0;
   logic               req_final_update = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_out_column;
   logic signed [31:0] rsp_out_row_0;
   logic signed [31:0] rsp_out_row_1;
   logic signed [31:0] rsp_out_row_2;
   logic signed [31:0] rsp_out_row_3;
   logic               rsp_tile_done;

   logic signed [63:0] acc_model [16];
   tile_column_type    expected_columns [$];
   int                 error_count = 0;
   int                 beats_sent = 0;
   int                 cycle_count = 0;
   bit                 calm = 1'b0;

   tile_outer_product_mac #(.TILE(4)) u_top (.*);

   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tile_outer_product_mac: mismatch");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("%0t bad result: %s", $time, msg);
      error_count++;
   endtask

   // random idle length, mostly short with a few long ones
   function automatic int idle_length(input bit may_be_zero);
      int roll;
      roll = $urandom_range(0, 19);
      if (calm) return may_be_zero ? 0 : 1;
      if (roll < 8 && may_be_zero) return 0;
      if (roll < 17) return $urandom_range(1, 3);
      return $urandom_range(6, 24);
   endfunction

   // Q32.32 to Q16.16, round half up, clamp to 32 bits
   function automatic logic signed [31:0] round_to_q16(input logic signed [63:0] acc);
      logic signed [65:0] biased;
      logic signed [65:0] q;
      biased = acc;
      biased = biased + 66'sd32768;
      q = biased >>> 16;
      if (q > 66'sd2147483647) return 32'sh7fffffff;
      if (q < -66'sd2147483648) return 32'sh80000000;
      return q[31:0];
   endfunction

   // accumulator add with clamp to the signed 64-bit range
   function automatic logic signed [63:0] clamp_add(input logic signed [63:0] acc,
                                                     input logic signed [63:0] prod);
      logic signed [64:0] sum;
      sum = acc;
      sum = sum + prod;
      if (sum[64] != sum[63])
         return sum[64] ? 64'sh8000_0000_0000_0000 : 64'sh7fff_ffff_ffff_ffff;
      return sum[63:0];
   endfunction

   // update the tile state for one accepted beat, queue any emitted columns
   function automatic void apply_beat(input mac_beat_type beat);
      tile_column_type    column;
      logic signed [63:0] prod;
      if (beat.op == OP_LOAD) begin
         for (int i = 0; i < 4; i++)
            acc_model[i + 4 * beat.col] = {{16{beat.a[i][31]}}, beat.a[i], 16'h0000};
         return;
      end
      for (int j = 0; j < 4; j++) begin
         for (int i = 0; i < 4; i++) begin
            prod = 64'(beat.a[i]) * 64'(beat.b[j]);
            acc_model[i + 4 * j] = clamp_add(acc_model[i + 4 * j], prod);
         end
      end
      if (!beat.fin) return;
      for (int j = 0; j < 4; j++) begin
         column.col = j[1:0];
         for (int i = 0; i < 4; i++)
            column.rows[i] = round_to_q16(acc_model[i + 4 * j]);
         column.done = (j == 3);
         expected_columns.push_back(column);
      end
   endfunction

   function automatic mac_beat_type beat_of(input op_type op, input logic [1:0] col,
                                            input int a0, input int a1, input int a2,
                                            input int a3, input int b0, input int b1,
                                            input int b2, input int b3, input bit fin);
      mac_beat_type beat;
      beat.op = op;
      beat.col = col;
      beat.a = '{a0, a1, a2, a3};
      beat.b = '{b0, b1, b2, b3};
      beat.fin = fin;
      return beat;
   endfunction

   // operand of random magnitude and sign
   function automatic logic signed [31:0] random_operand();
      logic signed [31:0] v;
      v = $urandom;
      if ($urandom_range(0, 3) == 0) return v;
      return v >>> $urandom_range(1, 31);
   endfunction

   function automatic mac_beat_type random_beat(input op_type op);
      mac_beat_type beat;
      beat.op = op;
      beat.col = 2'($urandom_range(0, 3));
      for (int i = 0; i < 4; i++) begin
         beat.a[i] = random_operand();
         beat.b[i] = random_operand();
      end
      beat.fin = (op == OP_LOAD) ? 1'($urandom_range(0, 1)) : 1'b0;
      return beat;
   endfunction

   // drive one beat and wait for it to be taken
   task automatic send_beat(input mac_beat_type beat);
      int gap;
      gap = idle_length(1'b1);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= beat.op;
      req_column_index <= beat.col;
      req_a_elem_0     <= beat.a[0];
      req_a_elem_1     <= beat.a[1];
      req_a_elem_2     <= beat.a[2];
      req_a_elem_3     <= beat.a[3];
      req_b_elem_0     <= beat.b[0];
      req_b_elem_1     <= beat.b[1];
      req_b_elem_2     <= beat.b[2];
      req_b_elem_3     <= beat.b[3];
      req_final_update <= beat.fin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      apply_beat(beat);
      beats_sent++;
   endtask

   // result side stall pattern
   initial begin
      @(posedge clock);
      forever begin
         rsp_stall <= 1'b0;
         repeat (calm ? 40 : $urandom_range(1, 10)) @(posedge clock);
         rsp_stall <= 1'b1;
         repeat (idle_length(1'b0)) @(posedge clock);
      end
   end

   // compare each result beat against the oldest pending column
   always @(posedge clock) begin : check_columns
      tile_column_type    want;
      logic signed [31:0] got_rows [4];
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_columns.size() == 0) begin
            report_mismatch("result beat with no column pending");
         end else begin
            want = expected_columns.pop_front();
            got_rows = '{rsp_out_row_0, rsp_out_row_1, rsp_out_row_2, rsp_out_row_3};
            if (rsp_out_column !== want.col)
               report_mismatch($sformatf("column got %0d want %0d", rsp_out_column,
                                         want.col));
            for (int i = 0; i < 4; i++) begin
               if (got_rows[i] !== want.rows[i])
                  report_mismatch($sformatf("col %0d row %0d got %h want %h", want.col, i,
                                            got_rows[i], want.rows[i]));
            end
            if (rsp_tile_done !== want.done)
               report_mismatch($sformatf("col %0d tile_done got %b want %b", want.col,
                                         rsp_tile_done, want.done));
         end
      end
   end

   // accumulators start at zero after reset
   task automatic test_reset_state();
      send_beat(beat_of(OP_UPDATE, 2'd0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
   endtask

   // full-scale loads and products
   task automatic test_extremes();
      send_beat(beat_of(OP_LOAD, 2'd0, 32'h7fffffff, 32'h80000000, 0, -1, 0, 0, 0, 0, 1'b0));
      send_beat(beat_of(OP_LOAD, 2'd1, 32'h80000000, 32'h7fffffff, -1, 0, 0, 0, 0, 0, 1'b0));
      send_beat(beat_of(OP_LOAD, 2'd2, 0, -1, 32'h7fffffff, 32'h80000000, -1, -1, -1, -1,
                        1'b0));
      send_beat(beat_of(OP_LOAD, 2'd3, -1, 0, 32'h80000000, 32'h7fffffff, 0, 0, 0, 0, 1'b0));
      send_beat(beat_of(OP_UPDATE, 2'd3, 32'h7fffffff, 32'h80000000, 1, -1,
                        32'h80000000, 32'h7fffffff, -1, 32'h00010000, 1'b1));
   endtask

   // final flag on a load does nothing
   task automatic test_final_on_load();
      send_beat(beat_of(OP_LOAD, 2'd2, 32'h00030000, -32'h00020000, 5, -5,
                        7, 7, 7, 7, 1'b1));
      send_beat(beat_of(OP_UPDATE, 2'd1, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
   endtask

   // half-lsb ties of both signs and their neighbors
   task automatic test_rounding();
      for (int c = 0; c < 4; c++)
         send_beat(beat_of(OP_LOAD, c[1:0], 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
      send_beat(beat_of(OP_UPDATE, 2'd0, 1, -1, 1, -1,
                        32'h8000, 32'h8000, 32'h7fff, 32'h8001, 1'b1));
   endtask

   // accumulators run into both 64-bit limits
   task automatic test_saturation();
      for (int k = 0; k < 3; k++)
         send_beat(beat_of(OP_UPDATE, 2'd0, 32'h80000000, 32'h80000000, 32'h7fffffff,
                           32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                           32'h7fffffff, k == 2));
   endtask

   // tile is kept after emitting, later updates keep adding
   task automatic test_reemit();
      send_beat(beat_of(OP_UPDATE, 2'd0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
      send_beat(beat_of(OP_UPDATE, 2'd0, 1, -1, 32'h7fffffff, 1, 1, -1, 1, 32'h7fffffff,
                        1'b1));
   endtask

   // loads (some columns skipped), then a run of updates
   task automatic send_tile(input bit finish);
      mac_beat_type beat;
      int           n_updates;
      n_updates = $urandom_range(1, 6);
      for (int c = 0; c < 4; c++) begin
         if ($urandom_range(0, 5) != 0) begin
            beat = random_beat(OP_LOAD);
            beat.col = c[1:0];
            send_beat(beat);
         end
      end
      for (int k = 0; k < n_updates; k++) begin
         beat = random_beat(OP_UPDATE);
         beat.fin = finish && (k == n_updates - 1);
         send_beat(beat);
      end
   endtask

   // mostly well-formed tiles, some unfinished tiles and stray beats
   task automatic test_random();
      mac_beat_type beat;
      int           target;
      int           roll;
      target = beats_sent + RANDOM_BEATS;
      while (beats_sent < target) begin
         calm = ($urandom_range(0, 5) == 0);
         roll = $urandom_range(0, 9);
         if (roll == 0) begin
            beat = random_beat(op_type'($urandom_range(0, 1)));
            beat.fin = 1'($urandom_range(0, 1));
            send_beat(beat);
         end else begin
            send_tile(roll != 1);
         end
      end
      calm = 1'b0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      for (int k = 0; k < 16; k++) acc_model[k] = '0;
      test_reset_state();
      test_extremes();
      test_final_on_load();
      test_rounding();
      test_saturation();
      test_reemit();
      test_random();
      req_valid <= 1'b0;
      while (expected_columns.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("tile_outer_product_mac: match");
      end else begin
         $display("tile_outer_product_mac: mismatch");
      end
      $finish;
   end

endmodule
